// ===== design/mocc_pkg.sv =====
package mocc_pkg;

   localparam int RAW_W    = 16;
   localparam int DIFF_W   = 17;
   localparam int PROD_W   = 34;
   localparam int FIELD_W  = 20;
   localparam int STATUS_W = 3;
   localparam int SCALE_W  = 16;
   localparam int SKIP_W   = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W = 3;
   localparam int AXES     = 3;
   localparam int FRAC_W   = 12;

   localparam int SKIP_SAMPLES_DEF = 2;
   localparam int PASS_SAMPLES_DEF = 20;

   localparam logic signed [RAW_W-1:0]   OVF_MARK    = -16'sd4096;
   localparam logic signed [RAW_W-1:0]   LIM_LO      = -16'sd4000;
   localparam logic signed [RAW_W-1:0]   LIM_HI      = 16'sd4000;
   localparam logic [SCALE_W-1:0]        SCALE_RESET = 16'd3758;
   localparam logic signed [FIELD_W-1:0] F_MAX       = 20'sd524287;
   localparam logic signed [FIELD_W-1:0] F_MIN       = -20'sd524288;

   localparam logic [STATUS_W-1:0] ST_REJECT = 3'd0;
   localparam logic [STATUS_W-1:0] ST_VALID  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CAL    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DONE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FAIL   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_PASS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_Z   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z  = 3'd7;

   typedef struct packed {
      logic upd;
      logic en1;
      logic en2;
   } lane_ctl_type;

endpackage

// ===== design/mocc_lane.sv =====
module mocc_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mocc_pkg::lane_ctl_type                 ctl,
   input  logic signed [mocc_pkg::RAW_W-1:0]      raw,
   input  logic signed [mocc_pkg::RAW_W-1:0]      offset,
   input  logic [mocc_pkg::SCALE_W-1:0]           scale,
   output logic signed [mocc_pkg::FIELD_W-1:0]    field,
   output logic signed [mocc_pkg::RAW_W-1:0]      centre,
   output logic                                   fail
);

   logic signed [mocc_pkg::RAW_W-1:0]   max_ff, max_in, min_ff, min_in;
   logic signed [mocc_pkg::DIFF_W-1:0]  diff_s1_ff;
   logic signed [mocc_pkg::RAW_W-1:0]   hi_s1_ff, lo_s1_ff;
   logic signed [mocc_pkg::PROD_W-1:0]  prod_s2_ff, prod_in;
   logic signed [mocc_pkg::RAW_W-1:0]   centre_s2_ff, centre_in;
   logic                                fail_s2_ff, fail_in;
   logic signed [mocc_pkg::DIFF_W-1:0]  sum;
   logic signed [mocc_pkg::PROD_W:0]    rnd;
   logic signed [mocc_pkg::PROD_W-mocc_pkg::FRAC_W:0] quo;

   always_comb begin
      max_in = (ctl.upd && raw > max_ff) ? raw : max_ff;
      min_in = (ctl.upd && raw < min_ff) ? raw : min_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= mocc_pkg::LIM_LO;
         min_ff <= mocc_pkg::LIM_HI;
      end else begin
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         diff_s1_ff <= {raw[mocc_pkg::RAW_W-1], raw} - {offset[mocc_pkg::RAW_W-1], offset};
         hi_s1_ff   <= max_in;
         lo_s1_ff   <= min_in;
      end
   end

   always_comb begin
      prod_in   = mocc_pkg::PROD_W'(diff_s1_ff)
                * mocc_pkg::PROD_W'($signed({1'b0, scale}));
      sum       = {hi_s1_ff[mocc_pkg::RAW_W-1], hi_s1_ff}
                + {lo_s1_ff[mocc_pkg::RAW_W-1], lo_s1_ff};
      sum       = sum + {{(mocc_pkg::DIFF_W-1){1'b0}}, sum[mocc_pkg::DIFF_W-1]};
      centre_in = sum[mocc_pkg::DIFF_W-1:1];
      fail_in   = (hi_s1_ff <= mocc_pkg::LIM_LO) || (lo_s1_ff >= mocc_pkg::LIM_HI);
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         prod_s2_ff   <= prod_in;
         centre_s2_ff <= centre_in;
         fail_s2_ff   <= fail_in;
      end
   end

   always_comb begin
      rnd = {prod_s2_ff[mocc_pkg::PROD_W-1], prod_s2_ff}
          + (mocc_pkg::PROD_W+1)'(1 << (mocc_pkg::FRAC_W-1));
      quo = rnd[mocc_pkg::PROD_W:mocc_pkg::FRAC_W];
      if (quo > (mocc_pkg::PROD_W-mocc_pkg::FRAC_W+1)'(mocc_pkg::F_MAX)) begin
         field = mocc_pkg::F_MAX;
      end else if (quo < (mocc_pkg::PROD_W-mocc_pkg::FRAC_W+1)'(mocc_pkg::F_MIN)) begin
         field = mocc_pkg::F_MIN;
      end else begin
         field = quo[mocc_pkg::FIELD_W-1:0];
      end
   end

   assign centre = centre_s2_ff;
   assign fail   = fail_s2_ff;

endmodule

// ===== design/mocc_merge.sv =====
module mocc_merge (
   input  logic                                                clock,
   input  logic                                                en,
   input  logic [mocc_pkg::STATUS_W-1:0]                       status_s2,
   input  logic                                                last_pass,
   input  logic [mocc_pkg::AXES-1:0][mocc_pkg::FIELD_W-1:0]    field,
   input  logic [mocc_pkg::AXES-1:0][mocc_pkg::RAW_W-1:0]      centre,
   input  logic [mocc_pkg::AXES-1:0]                           fail,
   output logic [mocc_pkg::STATUS_W-1:0]                       status,
   output logic [mocc_pkg::AXES-1:0][mocc_pkg::FIELD_W-1:0]    field_out,
   output logic [mocc_pkg::AXES-1:0][mocc_pkg::RAW_W-1:0]      offset_out
);

   logic [mocc_pkg::STATUS_W-1:0]                    status_ff, status_in;
   logic [mocc_pkg::AXES-1:0][mocc_pkg::FIELD_W-1:0] field_ff, field_in;
   logic [mocc_pkg::AXES-1:0][mocc_pkg::RAW_W-1:0]   offset_ff, offset_in;
   logic                                             checked;

   always_comb begin
      checked   = (status_s2 == mocc_pkg::ST_DONE) && last_pass;
      status_in = (checked && (|fail)) ? mocc_pkg::ST_FAIL : status_s2;
      field_in  = (status_s2 == mocc_pkg::ST_VALID) ? field : '0;
      offset_in = (checked && !(|fail)) ? centre : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= status_in;
         field_ff  <= field_in;
         offset_ff <= offset_in;
      end
   end

   assign status     = status_ff;
   assign field_out  = field_ff;
   assign offset_out = offset_ff;

endmodule

// ===== design/magnetometer_offset_cal_and_correct.sv =====
// Three-axis magnetometer hard-iron calibration and correction. One sample beat in,
// one result beat out, one beat per cycle sustained while rsp_tready stays high; the
// pipeline has difference, multiply and rounding stages, a 17x17 multiply per axis.
// A sample with any axis at -4096 returns status 0 and leaves all state untouched.
// Measure mode returns round((raw - offset) * scale / 4096), saturated to 20 bits.
// Calibration mode skips SKIP_SAMPLES good samples, then tracks per-axis min/max over
// PASS_SAMPLES samples (held till reset); on a last pass the end beat carries the
// range check and offsets (max+min)/2. Write CSRs only while no beat is in flight.
module magnetometer_offset_cal_and_correct #(
   parameter int SKIP_SAMPLES = mocc_pkg::SKIP_SAMPLES_DEF,
   parameter int PASS_SAMPLES = mocc_pkg::PASS_SAMPLES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,  // raw_x, raw_y, raw_z
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [111:0]                        rsp_tdata,  // field_x, field_y, field_z,
                                                           // new_offset_x/y/z, zero fill
   output logic [7:0]                          rsp_tuser,  // status, zero fill
   input  logic                                csr_we,
   input  logic [mocc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [15:0]                         csr_wdata
);

   logic                                  cal_mode_ff, last_pass_ff;
   logic [mocc_pkg::AXES-1:0][15:0]       scale_ff, offset_ff;
   logic [mocc_pkg::SKIP_W-1:0]           skip_ff, skip_in;
   logic [mocc_pkg::COUNT_W-1:0]          count_ff, count_in, count_inc;
   logic                                  v1_ff, v2_ff, v3_ff;
   logic [mocc_pkg::STATUS_W-1:0]         st1_ff, st2_ff, st_in;
   logic                                  en1, en2, en3, acc, rej;
   mocc_pkg::lane_ctl_type                ctl;
   logic [mocc_pkg::AXES-1:0][15:0]       raw;
   logic [mocc_pkg::AXES-1:0][mocc_pkg::FIELD_W-1:0] lane_field, field_o;
   logic [mocc_pkg::AXES-1:0][15:0]       lane_centre, offset_o;
   logic [mocc_pkg::AXES-1:0]             lane_fail;
   logic [mocc_pkg::STATUS_W-1:0]         status_o;

   assign raw = req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_mode_ff  <= 1'b0;
         last_pass_ff <= 1'b0;
         scale_ff     <= {mocc_pkg::AXES{mocc_pkg::SCALE_RESET}};
         offset_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            mocc_pkg::CSR_CAL_MODE:  cal_mode_ff  <= csr_wdata[0];
            mocc_pkg::CSR_LAST_PASS: last_pass_ff <= csr_wdata[0];
            mocc_pkg::CSR_SCALE_X:   scale_ff[0]  <= csr_wdata;
            mocc_pkg::CSR_SCALE_Y:   scale_ff[1]  <= csr_wdata;
            mocc_pkg::CSR_SCALE_Z:   scale_ff[2]  <= csr_wdata;
            mocc_pkg::CSR_OFFSET_X:  offset_ff[0] <= csr_wdata;
            mocc_pkg::CSR_OFFSET_Y:  offset_ff[1] <= csr_wdata;
            mocc_pkg::CSR_OFFSET_Z:  offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      en3        = !v3_ff || rsp_tready;
      en2        = !v2_ff || en3;
      en1        = !v1_ff || en2;
      req_tready = en1;
      acc        = req_tvalid && en1;
      rej        = (raw[0] == mocc_pkg::OVF_MARK) || (raw[1] == mocc_pkg::OVF_MARK)
                || (raw[2] == mocc_pkg::OVF_MARK);
      skip_in    = skip_ff;
      count_in   = count_ff;
      count_inc  = count_ff + mocc_pkg::COUNT_W'(1);
      ctl.upd    = 1'b0;
      ctl.en1    = en1;
      ctl.en2    = en2;
      if (rej) begin
         st_in = mocc_pkg::ST_REJECT;
      end else if (!cal_mode_ff) begin
         st_in = mocc_pkg::ST_VALID;
      end else if (skip_ff < mocc_pkg::SKIP_W'(SKIP_SAMPLES)) begin
         st_in   = mocc_pkg::ST_CAL;
         skip_in = skip_ff + mocc_pkg::SKIP_W'(1);
      end else begin
         ctl.upd = acc;
         if (count_inc >= mocc_pkg::COUNT_W'(PASS_SAMPLES)) begin
            st_in    = mocc_pkg::ST_DONE;
            skip_in  = '0;
            count_in = '0;
         end else begin
            st_in    = mocc_pkg::ST_CAL;
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff  <= '0;
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (acc) begin
            skip_ff  <= skip_in;
            count_ff <= count_in;
         end
         if (en1) v1_ff <= acc;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) st1_ff <= st_in;
      if (en2) st2_ff <= st1_ff;
   end

   for (genvar a = 0; a < mocc_pkg::AXES; a++) begin : g_lane
      mocc_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .raw    (raw[a]),
         .offset (offset_ff[a]),
         .scale  (scale_ff[a]),
         .field  (lane_field[a]),
         .centre (lane_centre[a]),
         .fail   (lane_fail[a])
      );
   end

   mocc_merge u_merge (
      .clock      (clock),
      .en         (en3),
      .status_s2  (st2_ff),
      .last_pass  (last_pass_ff),
      .field      (lane_field),
      .centre     (lane_centre),
      .fail       (lane_fail),
      .status     (status_o),
      .field_out  (field_o),
      .offset_out (offset_o)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {4'b0, offset_o, field_o};
   assign rsp_tuser  = {5'b0, status_o};

endmodule

// ===== sim/magnetometer_offset_cal_and_correct_tb.sv =====
module magnetometer_offset_cal_and_correct_tb;

   typedef struct packed {
      logic [mocc_pkg::STATUS_W-1:0] status;
      logic [mocc_pkg::FIELD_W-1:0]  field_x;
      logic [mocc_pkg::FIELD_W-1:0]  field_y;
      logic [mocc_pkg::FIELD_W-1:0]  field_z;
      logic [mocc_pkg::RAW_W-1:0]    ofs_x;
      logic [mocc_pkg::RAW_W-1:0]    ofs_y;
      logic [mocc_pkg::RAW_W-1:0]    ofs_z;
   } mag_result_type;

   class mag_scoreboard;
      logic                              cal_on;
      logic                              last_on;
      logic [mocc_pkg::SCALE_W-1:0]      scale [3];
      logic signed [mocc_pkg::RAW_W-1:0] offset [3];
      int                                hi [3];
      int                                lo [3];
      int                                skip_cnt;
      int                                sample_cnt;
      mag_result_type                    awaited_results [$];
      int                                errors;
      int                                beats;
      int                                seen [5];

      function new();
         cal_on     = 1'b0;
         last_on    = 1'b0;
         skip_cnt   = 0;
         sample_cnt = 0;
         errors     = 0;
         beats      = 0;
         for (int k = 0; k < 3; k++) begin
            scale[k]  = mocc_pkg::SCALE_RESET;
            offset[k] = '0;
            hi[k]     = int'(mocc_pkg::LIM_LO);
            lo[k]     = int'(mocc_pkg::LIM_HI);
         end
         for (int k = 0; k < 5; k++) begin
            seen[k] = 0;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function void set_reg(logic [mocc_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
         case (idx)
            mocc_pkg::CSR_CAL_MODE:  cal_on    = data[0];
            mocc_pkg::CSR_LAST_PASS: last_on   = data[0];
            mocc_pkg::CSR_SCALE_X:   scale[0]  = data;
            mocc_pkg::CSR_SCALE_Y:   scale[1]  = data;
            mocc_pkg::CSR_SCALE_Z:   scale[2]  = data;
            mocc_pkg::CSR_OFFSET_X:  offset[0] = data;
            mocc_pkg::CSR_OFFSET_Y:  offset[1] = data;
            mocc_pkg::CSR_OFFSET_Z:  offset[2] = data;
            default: ;
         endcase
      endfunction

      // round half up, then saturate to the field width
      function logic [mocc_pkg::FIELD_W-1:0] scaled(int raw, int axis);
         longint p;
         p = longint'(raw - int'(offset[axis])) * longint'(scale[axis]) + 2048;
         p = p >>> mocc_pkg::FRAC_W;
         if (p > mocc_pkg::F_MAX) p = mocc_pkg::F_MAX;
         if (p < mocc_pkg::F_MIN) p = mocc_pkg::F_MIN;
         return p[mocc_pkg::FIELD_W-1:0];
      endfunction

      function void note_sample(logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
         int             r [3];
         mag_result_type e;
         bit             out_of_range;
         r[0] = int'($signed(rx));
         r[1] = int'($signed(ry));
         r[2] = int'($signed(rz));
         e = '0;
         if (r[0] == mocc_pkg::OVF_MARK || r[1] == mocc_pkg::OVF_MARK
             || r[2] == mocc_pkg::OVF_MARK) begin
            e.status = mocc_pkg::ST_REJECT;
         end else if (!cal_on) begin
            e.status  = mocc_pkg::ST_VALID;
            e.field_x = scaled(r[0], 0);
            e.field_y = scaled(r[1], 1);
            e.field_z = scaled(r[2], 2);
         end else if (skip_cnt < mocc_pkg::SKIP_SAMPLES_DEF) begin
            skip_cnt++;
            e.status = mocc_pkg::ST_CAL;
         end else begin
            for (int k = 0; k < 3; k++) begin
               if (r[k] > hi[k]) hi[k] = r[k];
               if (r[k] < lo[k]) lo[k] = r[k];
            end
            sample_cnt++;
            if (sample_cnt >= mocc_pkg::PASS_SAMPLES_DEF) begin
               skip_cnt   = 0;
               sample_cnt = 0;
               e.status   = mocc_pkg::ST_DONE;
               if (last_on) begin
                  out_of_range = 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     if (hi[k] <= mocc_pkg::LIM_LO || lo[k] >= mocc_pkg::LIM_HI)
                        out_of_range = 1'b1;
                  end
                  if (out_of_range) begin
                     e.status = mocc_pkg::ST_FAIL;
                  end else begin
                     e.ofs_x = 16'((hi[0] + lo[0]) / 2);
                     e.ofs_y = 16'((hi[1] + lo[1]) / 2);
                     e.ofs_z = 16'((hi[2] + lo[2]) / 2);
                  end
               end
            end else begin
               e.status = mocc_pkg::ST_CAL;
            end
         end
         awaited_results.push_back(e);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         if (errors < 50)
            $display("%s mismatch on beat %0d: got %0h, expected %0h", what, beats, got, want);
         errors++;
      endtask

      task check_result(logic [7:0] user, logic [111:0] data);
         mag_result_type e;
         beats++;
         if (awaited_results.size() == 0) begin
            report("unexpected beat", 32'(user), 0);
            return;
         end
         e = awaited_results.pop_front();
         if (e.status < 5) seen[e.status]++;
         if (user[mocc_pkg::STATUS_W-1:0] != e.status)
            report("status", 32'(user[mocc_pkg::STATUS_W-1:0]), 32'(e.status));
         if (data[19:0] != e.field_x) report("field_x", 32'(data[19:0]), 32'(e.field_x));
         if (data[39:20] != e.field_y) report("field_y", 32'(data[39:20]), 32'(e.field_y));
         if (data[59:40] != e.field_z) report("field_z", 32'(data[59:40]), 32'(e.field_z));
         if (data[75:60] != e.ofs_x)
            report("new_offset_x", 32'(data[75:60]), 32'(e.ofs_x));
         if (data[91:76] != e.ofs_y)
            report("new_offset_y", 32'(data[91:76]), 32'(e.ofs_y));
         if (data[107:92] != e.ofs_z)
            report("new_offset_z", 32'(data[107:92]), 32'(e.ofs_z));
         if (data[111:108] != '0 || user[7:mocc_pkg::STATUS_W] != '0)
            report("zero fill", 32'({user[7:mocc_pkg::STATUS_W], data[111:108]}), 0);
      endtask
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [47:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [111:0]                   rsp_tdata;
   logic [7:0]                     rsp_tuser;
   logic                           csr_we     = 1'b0;
   logic [mocc_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]                    csr_wdata  = '0;

   mag_scoreboard sb = new();
   bit            steady_send = 1'b0;
   bit            hold_rsp    = 1'b0;
   int            sent        = 0;

   magnetometer_offset_cal_and_correct dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return mocc_pkg::LIM_LO;
         3: return mocc_pkg::LIM_HI;
         4: return 16'hF001;
         5, 6: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 8000)) - 4000);
      endcase
   endfunction

   function automatic logic [15:0] pick_scale();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return mocc_pkg::SCALE_RESET;
         3: return 16'h1000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int gap;
      gap = steady_send ? 0 : $urandom_range(0, 7);
      csr_we <= 1'b0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(x, y, z);
      sent++;
   endtask

   task automatic idle_wait();
      req_tvalid <= 1'b0;
      csr_we     <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(logic [mocc_pkg::CSR_IDX_W-1:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic send_random(bit noisy);
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      x = pick_raw();
      y = pick_raw();
      z = pick_raw();
      if (noisy && $urandom_range(0, 11) == 0) begin
         case ($urandom_range(0, 2))
            0: x = mocc_pkg::OVF_MARK;
            1: y = mocc_pkg::OVF_MARK;
            default: z = mocc_pkg::OVF_MARK;
         endcase
      end
      send_sample(x, y, z);
   endtask

   // receiver: random stalls, quiet stretches, and a long hold on request
   initial begin
      int wait_cycles;
      int span;
      bit quick;
      span  = 0;
      quick = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (span == 0) begin
            quick = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(10, 60);
         end
         span--;
         wait_cycles = quick ? 0 : $urandom_range(0, 7);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   initial begin
      int n;
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: rejects on each axis, raw extremes
      send_sample(mocc_pkg::OVF_MARK, 16'h0000, 16'h0000);
      send_sample(16'h0000, mocc_pkg::OVF_MARK, 16'h0000);
      send_sample(16'h0000, 16'h0000, mocc_pkg::OVF_MARK);
      send_sample(16'h7FFF, 16'h8000, 16'h0000);
      send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
      send_sample(16'hF001, 16'h1000, 16'hEFFF);
      idle_wait();

      // saturation both ways and rounding of halves
      write_reg(mocc_pkg::CSR_SCALE_X, 16'hFFFF);
      write_reg(mocc_pkg::CSR_SCALE_Y, 16'hFFFF);
      write_reg(mocc_pkg::CSR_SCALE_Z, 16'h0001);
      write_reg(mocc_pkg::CSR_OFFSET_X, 16'h8000);
      write_reg(mocc_pkg::CSR_OFFSET_Y, 16'h7FFF);
      write_reg(mocc_pkg::CSR_OFFSET_Z, 16'h0001);
      send_sample(16'h7FFF, 16'h8000, 16'd2049);
      send_sample(16'h8000, 16'h7FFF, 16'hF801);
      send_sample(16'h0000, 16'h0000, 16'hF800);
      idle_wait();

      // first last pass: x never below the upper limit, so the range check fails;
      // a switch to measure mode and a reject fall in the middle of it
      write_reg(mocc_pkg::CSR_CAL_MODE, 16'd1);
      write_reg(mocc_pkg::CSR_LAST_PASS, 16'd1);
      for (int i = 0; i < 10; i++)
         send_sample(16'($urandom_range(4000, 32767)), pick_raw(), pick_raw());
      idle_wait();
      write_reg(mocc_pkg::CSR_CAL_MODE, 16'd0);
      send_random(1'b0);
      send_random(1'b0);
      idle_wait();
      write_reg(mocc_pkg::CSR_CAL_MODE, 16'd1);
      send_sample(16'd5000, mocc_pkg::OVF_MARK, 16'h0000);
      for (int i = 0; i < 12; i++)
         send_sample(16'($urandom_range(4000, 32767)), pick_raw(), pick_raw());
      idle_wait();

      phase = 0;
      while (sent < 800) begin
         phase++;
         steady_send = ($urandom_range(0, 3) == 0);
         if (phase == 1 || $urandom_range(0, 3) == 0) begin
            for (int k = 0; k < 3; k++) begin
               write_reg(mocc_pkg::CSR_IDX_W'(mocc_pkg::CSR_SCALE_X + k), pick_scale());
               write_reg(mocc_pkg::CSR_IDX_W'(mocc_pkg::CSR_OFFSET_X + k), pick_raw());
            end
            write_reg(mocc_pkg::CSR_CAL_MODE, 16'd0);
            if (phase == 1 || $urandom_range(0, 7) == 0) begin
               hold_rsp    = 1'b1;
               steady_send = 1'b1;
               n = 40;
            end else begin
               n = $urandom_range(5, 40);
            end
         end else begin
            write_reg(mocc_pkg::CSR_CAL_MODE, 16'd1);
            write_reg(mocc_pkg::CSR_LAST_PASS, 16'($urandom_range(0, 1)));
            n = $urandom_range(5, 45);
         end
         for (int i = 0; i < n; i++)
            send_random(1'b1);
         idle_wait();
      end
      steady_send = 1'b0;

      repeat (20) @(posedge clock);
      $display("Ran %0d samples in %0d phases of measure and calibration traffic", sent, phase);
      $display("Results: %0d rejected, %0d corrected, %0d calibrating, %0d pass ends, %0d %s",
               sb.seen[mocc_pkg::ST_REJECT], sb.seen[mocc_pkg::ST_VALID],
               sb.seen[mocc_pkg::ST_CAL], sb.seen[mocc_pkg::ST_DONE],
               sb.seen[mocc_pkg::ST_FAIL], "range fails");
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
